>>> design/mwcrc_pkg.sv
// shared types and constants of the multi-width crc engine
// used by mwcrc_cfg, mwcrc_fold and multi_width_crc_engine
`timescale 1ns / 1ps
`default_nettype none

package mwcrc_pkg;

    typedef enum logic [1:0] {
        MODE_CRC8  = 2'd0,
        MODE_CRC16 = 2'd1,
        MODE_CRC32 = 2'd2,
        MODE_CRC64 = 2'd3
    } crc_mode_t;

    typedef enum logic [1:0] {
        REG_CRC_MODE = 2'd0,
        REG_POLY     = 2'd1,
        REG_INIT     = 2'd2,
        REG_XOROUT   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        crc_mode_t   mode;
        logic [31:0] poly;
        logic [31:0] init;
        logic [31:0] xorout;
    } cfg_t;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 32;

    localparam logic [7:0]  Poly8        = 8'h07;
    localparam logic [15:0] Poly16       = 16'h1021;
    localparam logic [63:0] Poly64       = 64'h42F0_E1EB_A9EA_3693;
    localparam logic [15:0] Init16       = 16'hFFFF;
    localparam logic [63:0] Init64       = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ResetPoly32  = 32'h04C1_1DB7;
    localparam logic [31:0] ResetInit32  = 32'hFFFF_FFFF;
    localparam logic [31:0] ResetXor32   = 32'hFFFF_FFFF;
    localparam crc_mode_t   ResetMode    = MODE_CRC32;

endpackage

`default_nettype wire

>>> design/mwcrc_cfg.sv
// configuration registers: mode, crc-32 polynomial, start value and final xor
// depends on mwcrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mwcrc_cfg (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write_en,
    input  wire logic [mwcrc_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [mwcrc_pkg::CfgDataWidth-1:0]    cfg_data,
    output mwcrc_pkg::cfg_t                            cfg
);

    mwcrc_pkg::cfg_t cfg_reg;
    mwcrc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (mwcrc_pkg::cfg_reg_t'(cfg_index))
                mwcrc_pkg::REG_CRC_MODE: cfg_next.mode   = mwcrc_pkg::crc_mode_t'(cfg_data[1:0]);
                mwcrc_pkg::REG_POLY:     cfg_next.poly   = cfg_data;
                mwcrc_pkg::REG_INIT:     cfg_next.init   = cfg_data;
                mwcrc_pkg::REG_XOROUT:   cfg_next.xorout = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= mwcrc_pkg::ResetMode;
            cfg_reg.poly   <= mwcrc_pkg::ResetPoly32;
            cfg_reg.init   <= mwcrc_pkg::ResetInit32;
            cfg_reg.xorout <= mwcrc_pkg::ResetXor32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/mwcrc_fold.sv
// one-byte fold: picks start value, runs eight shift-xor steps for the mode,
// applies the final xor in crc-32 mode; depends on mwcrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mwcrc_fold (
    input  mwcrc_pkg::cfg_t   cfg,
    input  wire logic [63:0]  rem_in,
    input  wire logic [7:0]   data_byte,
    input  wire logic         first_byte,
    output logic [63:0]       rem_out,
    output logic [63:0]       crc_out
);

    function automatic logic [7:0] fold8(input logic [7:0] r_in, input logic [7:0] d);
        logic [7:0] r;
        r = r_in ^ d;
        for (int k = 0; k < 8; k++)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ mwcrc_pkg::Poly8) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [15:0] fold16(input logic [15:0] r_in, input logic [7:0] d);
        logic [15:0] r;
        r = r_in ^ {d, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            r = r[15] ? ({r[14:0], 1'b0} ^ mwcrc_pkg::Poly16) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [31:0] fold32(input logic [31:0] r_in, input logic [7:0] d,
                                           input logic [31:0] poly);
        logic [31:0] r;
        r = r_in ^ {24'h0, d};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ({1'b0, r[31:1]} ^ poly) : {1'b0, r[31:1]};
        end
        return r;
    endfunction

    function automatic logic [63:0] fold64(input logic [63:0] r_in, input logic [7:0] d);
        logic [63:0] r;
        r = r_in ^ {56'h0, d};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ({1'b0, r[63:1]} ^ mwcrc_pkg::Poly64) : {1'b0, r[63:1]};
        end
        return r;
    endfunction

    logic [63:0] start;

    always_comb
    begin
        start   = rem_in;
        rem_out = '0;
        crc_out = '0;
        unique case (cfg.mode)
            mwcrc_pkg::MODE_CRC8:
            begin
                if (first_byte)
                begin
                    start = '0;
                end
                rem_out = {56'h0, fold8(start[7:0], data_byte)};
                crc_out = rem_out;
            end
            mwcrc_pkg::MODE_CRC16:
            begin
                if (first_byte)
                begin
                    start = {48'h0, mwcrc_pkg::Init16};
                end
                rem_out = {48'h0, fold16(start[15:0], data_byte)};
                crc_out = rem_out;
            end
            mwcrc_pkg::MODE_CRC32:
            begin
                if (first_byte)
                begin
                    start = {32'h0, cfg.init};
                end
                rem_out = {32'h0, fold32(start[31:0], data_byte, cfg.poly)};
                crc_out = rem_out ^ {32'h0, cfg.xorout};
            end
            mwcrc_pkg::MODE_CRC64:
            begin
                if (first_byte)
                begin
                    start = mwcrc_pkg::Init64;
                end
                rem_out = fold64(start, data_byte);
                crc_out = rem_out;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/multi_width_crc_engine.sv
// top level: input register, byte fold, running remainder, result register
// depends on mwcrc_pkg, mwcrc_cfg, mwcrc_fold
// the fold between the input register and the remainder/result registers
// carries each byte; throughput: one byte per cycle unless a last byte
// waits on a full, stalled result slot, which holds the input register
// reset: clears valids and the remainder, loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module multi_width_crc_engine (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [7:0]                            data_byte,
    input  wire logic                                  first_byte,
    input  wire logic                                  last_byte,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [63:0]                                crc_value,
    input  wire logic                                  cfg_write_en,
    input  wire logic [mwcrc_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [mwcrc_pkg::CfgDataWidth-1:0]    cfg_data
);

    mwcrc_pkg::cfg_t cfg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_data_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic        s1_move;
    logic        in_fire;

    logic [63:0] rem_reg;
    logic [63:0] rem_next;
    logic [63:0] crc_out;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] crc_reg;

    mwcrc_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    mwcrc_fold u_fold (
        .cfg        (cfg),
        .rem_in     (rem_reg),
        .data_byte  (s1_data_reg),
        .first_byte (s1_first_reg),
        .rem_out    (rem_next),
        .crc_out    (crc_out)
    );

    // a last byte needs a free result slot
    assign s1_move  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (s1_move && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                rem_reg <= rem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
        if (s1_move && s1_last_reg)
        begin
            crc_reg <= crc_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_reg;

    // stall only when a last byte waits on a full result slot
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked last byte");

    // a folded last byte always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_last_reg) |=> out_valid_reg)
        else $error("last byte folded but no result presented");

    // a result only appears after a last byte was folded
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result presented without a last byte");

endmodule

`default_nettype wire

>>> bench/tb.sv
// self-checking bench for multi_width_crc_engine: byte requests and register writes
// go in, finished checksums are checked against a bitwise crc predictor in the bench
// depends on mwcrc_pkg and multi_width_crc_engine
`timescale 1ns / 1ps

module tb;

    localparam logic [63:0] CrcPoly8     = 64'h07;
    localparam logic [63:0] CrcPoly16    = 64'h1021;
    localparam logic [63:0] CrcPoly64    = 64'h42F0_E1EB_A9EA_3693;
    localparam logic [63:0] CrcStart16   = 64'hFFFF;
    localparam logic [63:0] CrcStart64   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          SettleCycles = 8;
    localparam int          QuietLimit   = 2000;
    localparam int          RandomPhases = 24;
    localparam int          PhaseBytes   = 84;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       drain;
    } crc_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] crc_value;
    logic        cfg_write_en = 1'b0;
    logic [mwcrc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
    logic [mwcrc_pkg::CfgDataWidth-1:0]  cfg_data = '0;

    crc_request_t byte_requests[$];
    logic [63:0]  crc_expected[$];
    crc_request_t next_req;

    mwcrc_pkg::crc_mode_t model_mode;
    logic [31:0] model_poly;
    logic [31:0] model_init;
    logic [31:0] model_xorout;
    logic [63:0] model_rem;

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    logic        in_taken = 1'b0;

    multi_width_crc_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .crc_value    (crc_value),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] width_mask(mwcrc_pkg::crc_mode_t mode);
        case (mode)
            mwcrc_pkg::MODE_CRC8:  return 64'hFF;
            mwcrc_pkg::MODE_CRC16: return 64'hFFFF;
            mwcrc_pkg::MODE_CRC32: return 64'hFFFF_FFFF;
            default:               return 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    function automatic logic [63:0] fold_crc_byte(mwcrc_pkg::crc_mode_t mode,
                                                  logic [63:0] rem,
                                                  logic [7:0] data, logic [31:0] poly32);
        logic [63:0] mask;
        logic [63:0] poly;
        logic        fb;
        int          top;
        mask = width_mask(mode);
        if (mode == mwcrc_pkg::MODE_CRC8 || mode == mwcrc_pkg::MODE_CRC16)
        begin
            top  = (mode == mwcrc_pkg::MODE_CRC8) ? 7 : 15;
            poly = (mode == mwcrc_pkg::MODE_CRC8) ? CrcPoly8 : CrcPoly16;
            rem  = rem ^ (64'(data) << (top - 7));
            for (int k = 0; k < 8; k++)
            begin
                fb  = rem[top];
                rem = (rem << 1) & mask;
                if (fb)
                    rem = rem ^ poly;
            end
        end
        else
        begin
            poly = (mode == mwcrc_pkg::MODE_CRC32) ? {32'h0, poly32} : CrcPoly64;
            rem  = rem ^ 64'(data);
            for (int k = 0; k < 8; k++)
            begin
                fb  = rem[0];
                rem = rem >> 1;
                if (fb)
                    rem = rem ^ poly;
            end
        end
        return rem & mask;
    endfunction

    task automatic predict_crc(logic [7:0] data, logic first, logic last);
        logic [63:0] mask;
        logic [63:0] rem;
        mask = width_mask(model_mode);
        rem  = model_rem;
        if (first)
        begin
            case (model_mode)
                mwcrc_pkg::MODE_CRC8:  rem = 64'h0;
                mwcrc_pkg::MODE_CRC16: rem = CrcStart16;
                mwcrc_pkg::MODE_CRC32: rem = {32'h0, model_init};
                default:               rem = CrcStart64;
            endcase
        end
        rem = fold_crc_byte(model_mode, rem & mask, data, model_poly);
        model_rem = rem;
        if (last)
        begin
            if (model_mode == mwcrc_pkg::MODE_CRC32)
                rem = rem ^ {32'h0, model_xorout};
            crc_expected.push_back(rem & mask);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s, got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // monitor: predictor update, result check, watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            model_mode   = mwcrc_pkg::MODE_CRC32;
            model_poly   = 32'h04C1_1DB7;
            model_init   = 32'hFFFF_FFFF;
            model_xorout = 32'hFFFF_FFFF;
            model_rem    = 64'h0;
            in_taken     = 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (mwcrc_pkg::cfg_reg_t'(cfg_index))
                    mwcrc_pkg::REG_CRC_MODE:
                        model_mode = mwcrc_pkg::crc_mode_t'(cfg_data[1:0]);
                    mwcrc_pkg::REG_POLY:     model_poly   = cfg_data;
                    mwcrc_pkg::REG_INIT:     model_init   = cfg_data;
                    mwcrc_pkg::REG_XOROUT:   model_xorout = cfg_data;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (crc_expected.size() == 0)
                    report_mismatch("result with none expected", crc_value, 64'h0);
                else if (crc_value !== crc_expected[0])
                    report_mismatch("crc_value", crc_value, crc_expected.pop_front());
                else
                    void'(crc_expected.pop_front());
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                predict_crc(data_byte, first_byte, last_byte);
                bytes_taken++;
            end
            if (in_taken || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("watchdog: no progress for %0d cycles", QuietLimit);
                $display("** multi_width_crc_engine: FAILED **");
                $finish;
            end
        end
    end

    // driver: one request per handshake, random gaps
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
        if (rst_n && (!in_valid || in_taken))
        begin
            if (byte_requests.size() != 0 && !(byte_requests[0].drain && crc_expected.size() != 0)
                && $urandom_range(99) >= idle_pct)
            begin
                next_req = byte_requests.pop_front();
                in_valid   <= 1'b1;
                data_byte  <= next_req.data;
                first_byte <= next_req.first;
                last_byte  <= next_req.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic queue_byte(logic [7:0] data, logic first, logic last, logic drain = 1'b0);
        crc_request_t req;
        req.data  = data;
        req.first = first;
        req.last  = last;
        req.drain = drain;
        byte_requests.push_back(req);
        bytes_queued++;
    endtask

    task automatic queue_message(int len, logic drain);
        for (int i = 0; i < len; i++)
            queue_byte(8'($urandom), i == 0, i == len - 1, drain && i == 0);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (bytes_taken != bytes_queued || crc_expected.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(mwcrc_pkg::cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word(logic [31:0] typical);
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return typical;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int count;
        int pick;
        int len;
        logic drained;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        idle_pct  = 13;
        stall_pct = 52;

        // no first mark after reset, continuing after the end, one-byte messages
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h80, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b1, 1'b1);
        queue_byte(8'hFF, 1'b1, 1'b1);
        wait_drained();

        // each variant with a short message
        for (int m = 0; m < 4; m++)
        begin
            write_reg(mwcrc_pkg::REG_CRC_MODE, (32'($urandom) & ~32'h3) | 32'(m));
            queue_byte(8'h01, 1'b1, 1'b0);
            queue_byte(8'hFF, 1'b0, 1'b0);
            queue_byte(8'h00, 1'b0, 1'b1);
            wait_drained();
        end

        // mode change in mid-message
        queue_byte(8'hA5, 1'b1, 1'b0);
        wait_drained();
        write_reg(mwcrc_pkg::REG_CRC_MODE, 32'(mwcrc_pkg::MODE_CRC8));
        queue_byte(8'h3C, 1'b0, 1'b1);
        wait_drained();

        // init taken on the first byte, xorout on the last byte
        write_reg(mwcrc_pkg::REG_CRC_MODE, 32'(mwcrc_pkg::MODE_CRC32));
        queue_byte(8'h5A, 1'b1, 1'b0);
        wait_drained();
        write_reg(mwcrc_pkg::REG_INIT, 32'h0000_0000);
        write_reg(mwcrc_pkg::REG_XOROUT, 32'h0000_0000);
        queue_byte(8'hC3, 1'b0, 1'b1);
        wait_drained();

        for (int phase = 0; phase < RandomPhases; phase++)
        begin
            if (phase < RandomPhases / 3)
            begin
                idle_pct  = 13;
                stall_pct = 52;
            end
            else if (phase < 2 * RandomPhases / 3)
            begin
                idle_pct  = 52;
                stall_pct = 13;
            end
            else
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            if ($urandom_range(3) != 0)
                write_reg(mwcrc_pkg::REG_CRC_MODE,
                          (32'($urandom) & ~32'h3) | 32'(phase % 4));
            if ($urandom_range(2) != 0)
                write_reg(mwcrc_pkg::REG_POLY, pick_word(32'hEDB8_8320));
            if ($urandom_range(2) != 0)
                write_reg(mwcrc_pkg::REG_INIT, pick_word(32'hFFFF_FFFF));
            if ($urandom_range(2) != 0)
                write_reg(mwcrc_pkg::REG_XOROUT, pick_word(32'hFFFF_FFFF));
            count   = 0;
            drained = 1'b0;
            while (count < PhaseBytes)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                begin
                    len = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 24);
                    queue_message(len, !drained && count > 10);
                    if (count > 10)
                        drained = 1'b1;
                    count += len;
                end
                else
                begin
                    // noise and broken messages
                    queue_byte(8'($urandom), 1'($urandom), 1'($urandom));
                    count++;
                end
            end
            wait_drained();
        end

        if (crc_expected.size() != 0)
            report_mismatch("results never delivered", 64'h0, crc_expected[0]);
        if (error_count == 0)
            $display("** multi_width_crc_engine: PASSED **");
        else
            $display("** multi_width_crc_engine: FAILED **");
        $finish;
    end

endmodule
